FILE: sv/multichannel_sample_statistics_defines.svh
// Assertion helpers for the checker of this block.
// Both expect clk_i and rst_ni in scope.
`ifndef MULTICHANNEL_SAMPLE_STATISTICS_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_STATISTICS_DEFINES_SVH

// Implication checked in the same cycle.
`define MSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mss_pkg.sv
`default_nettype none

package mss_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF   = 24;
  localparam int unsigned SAMPLE_W         = 12;
  localparam int unsigned CHAN_W           = 4;
  localparam int unsigned MEAN_W           = 16;
  localparam int unsigned FRAC_W           = 4;
  localparam int unsigned LIVE_CNT_W       = 24;
  localparam int unsigned QUEUE_DEPTH      = 2;
  // one quotient bit per step
  localparam int unsigned DIV_STEPS        = MEAN_W;
  localparam int unsigned STEP_W           = $clog2(DIV_STEPS);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_BOUNDARY = 2'd1,
    OP_QUERY    = 2'd2
  } opcode_e;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_BOUNDARY = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_MISS     = 2'd3   // query of a channel that does not exist
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SAMPLE_W-1:0] sample_value;
    logic [CHAN_W-1:0]   channel;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   min_sample;
    logic [SAMPLE_W-1:0]   max_sample;
    logic [MEAN_W-1:0]     mean_value;
    logic [SAMPLE_W-1:0]   latest_sample;
    logic [LIVE_CNT_W-1:0] live_count;
    logic                  no_samples;
  } result_t;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] value;
  } cmd_t;

  // control strobes of the back engine, decoded from its state and handshake inputs
  typedef struct packed {
    logic take_cmd;
    logic div_step;
    logic emit;
  } back_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/mss_fifo.sv
`default_nettype none

module mss_fifo #(
  parameter int unsigned DEPTH = mss_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mss_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mss_pkg::cmd_t data_o,
  output logic          valid_o
);
  import mss_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mss_front.sv
`default_nettype none

module mss_front #(
  parameter int unsigned NUM_CHANNELS = mss_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mss_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              cmd_push_o,
  output mss_pkg::cmd_t     cmd_o
);
  import mss_pkg::*;

  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [IW-1:0] ptr_q, ptr_d;
  logic          accept, known;

  assign accept = push_i && !q_full_i;

  // resolve the round-robin channel here so the back sees a plain address
  always_comb begin
    cmd_o.kind  = CMD_SAMPLE;
    cmd_o.chan  = CHAN_W'(ptr_q);
    cmd_o.value = in_item_i.sample_value;
    known       = 1'b1;
    case (in_item_i.opcode)
      OP_SAMPLE: begin
        cmd_o.kind = CMD_SAMPLE;
      end
      OP_BOUNDARY: begin
        cmd_o.kind = CMD_BOUNDARY;
      end
      OP_QUERY: begin
        cmd_o.chan = in_item_i.channel;
        cmd_o.kind = (32'(in_item_i.channel) >= NUM_CHANNELS) ? CMD_MISS : CMD_QUERY;
      end
      default: begin
        known = 1'b0;   // unused opcode is dropped
      end
    endcase
  end

  assign cmd_push_o = accept && known;

  always_comb begin
    ptr_d = ptr_q;
    if (accept && (in_item_i.opcode == OP_SAMPLE)) begin
      ptr_d = (ptr_q == IW'(NUM_CHANNELS - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= IW'(NUM_CHANNELS - 1);
    end else begin
      ptr_q <= ptr_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mss_back.sv
`default_nettype none

module mss_back #(
  parameter int unsigned NUM_CHANNELS = mss_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned COUNT_BITS   = mss_pkg::COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mss_pkg::cmd_t    cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  output mss_pkg::result_t result_o,
  output logic             result_valid_o,
  input  logic             result_pop_i
);
  import mss_pkg::*;

  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TW = COUNT_BITS + SAMPLE_W;

  // live and snapshot sets, one entry per channel
  logic [SAMPLE_W-1:0]   live_min_q  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]   live_max_q  [NUM_CHANNELS];
  logic [TW-1:0]         live_tot_q  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] live_cnt_q  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]   snap_min_q  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]   snap_max_q  [NUM_CHANNELS];
  logic [TW-1:0]         snap_tot_q  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] snap_cnt_q  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]   recent_q    [NUM_CHANNELS];

  back_state_e state_q, state_d;
  back_ctrl_t  ctrl;

  logic [IW-1:0]         idx;
  logic                  do_sample, do_boundary, do_query, snap_empty;
  logic [LIVE_CNT_W-1:0] cnt_out;

  // divider
  logic [COUNT_BITS-1:0] rem_q, divisor_q;
  logic [MEAN_W-1:0]     sh_q;     // dividend low bits in, quotient bits out
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  ge;

  result_t res_q, out_q;
  logic    out_valid_q;

  assign idx         = cmd_i.chan[IW-1:0];
  assign do_sample   = ctrl.take_cmd && (cmd_i.kind == CMD_SAMPLE);
  assign do_boundary = ctrl.take_cmd && (cmd_i.kind == CMD_BOUNDARY);
  assign do_query    = ctrl.take_cmd && (cmd_i.kind == CMD_QUERY);
  assign snap_empty  = (snap_cnt_q[idx] == '0);
  assign cmd_pop_o   = ctrl.take_cmd;

  if (COUNT_BITS >= LIVE_CNT_W) begin : g_cnt_trunc
    assign cnt_out = live_cnt_q[idx][LIVE_CNT_W-1:0];
  end else begin : g_cnt_ext
    assign cnt_out = {{(LIVE_CNT_W - COUNT_BITS){1'b0}}, live_cnt_q[idx]};
  end

  assign trial = {rem_q, sh_q[MEAN_W-1]};
  assign ge    = (trial >= {1'b0, divisor_q});
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          ctrl.take_cmd = 1'b1;
          if (cmd_i.kind == CMD_MISS) begin
            state_d = BK_DONE;
          end else if (cmd_i.kind == CMD_QUERY) begin
            state_d = snap_empty ? BK_DONE : BK_DIV;
          end
        end
      end
      BK_DIV: begin
        ctrl.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || result_pop_i) begin
          ctrl.emit = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (result_pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.take_cmd) begin
        step_q <= '0;
      end else if (ctrl.div_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // statistics sets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        live_min_q[i] <= FULL_SCALE;
        live_max_q[i] <= '0;
        live_tot_q[i] <= '0;
        live_cnt_q[i] <= '0;
        snap_min_q[i] <= '0;
        snap_max_q[i] <= '0;
        snap_tot_q[i] <= '0;
        snap_cnt_q[i] <= '0;
        recent_q[i]   <= '0;
      end
    end else if (do_boundary) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        snap_min_q[i] <= live_min_q[i];
        snap_max_q[i] <= live_max_q[i];
        snap_tot_q[i] <= live_tot_q[i];
        snap_cnt_q[i] <= live_cnt_q[i];
        live_min_q[i] <= FULL_SCALE;
        live_max_q[i] <= '0;
        live_tot_q[i] <= '0;
        live_cnt_q[i] <= '0;
      end
    end else if (do_sample) begin
      if (cmd_i.value < live_min_q[idx]) begin
        live_min_q[idx] <= cmd_i.value;
      end
      if (cmd_i.value > live_max_q[idx]) begin
        live_max_q[idx] <= cmd_i.value;
      end
      // count saturates; total freezes with it
      if (!(&live_cnt_q[idx])) begin
        live_tot_q[idx] <= live_tot_q[idx] + TW'(cmd_i.value);
        live_cnt_q[idx] <= live_cnt_q[idx] + 1'b1;
      end
      recent_q[idx] <= cmd_i.value;
    end
  end

  // query capture, division and result register
  always_ff @(posedge clk_i) begin
    if (ctrl.take_cmd) begin
      if (do_query) begin
        res_q.min_sample    <= snap_min_q[idx];
        res_q.max_sample    <= snap_max_q[idx];
        res_q.latest_sample <= recent_q[idx];
        res_q.live_count    <= cnt_out;
        res_q.no_samples    <= snap_empty;
        res_q.mean_value    <= '0;
        divisor_q           <= snap_cnt_q[idx];
        rem_q               <= snap_tot_q[idx][TW-1:SAMPLE_W];
        sh_q                <= snap_empty ? '0
                             : {snap_tot_q[idx][SAMPLE_W-1:0], {FRAC_W{1'b0}}};
      end else begin
        res_q.min_sample    <= '0;
        res_q.max_sample    <= '0;
        res_q.latest_sample <= '0;
        res_q.live_count    <= '0;
        res_q.no_samples    <= 1'b1;
        res_q.mean_value    <= '0;
        sh_q                <= '0;
      end
    end else if (ctrl.div_step) begin
      rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      sh_q  <= {sh_q[MEAN_W-2:0], ge};
    end
    if (ctrl.emit) begin
      out_q <= {res_q.min_sample, res_q.max_sample, sh_q, res_q.latest_sample,
                res_q.live_count, res_q.no_samples};
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/multichannel_sample_statistics.sv
`default_nettype none

// Per-channel min/max/mean statistics over 12-bit converter samples.
// Input beats enter through a queue-style port (push/full). A sample beat is
// credited to the round-robin channel pointer, which starts at the last
// channel after reset; a boundary beat moves every live set into the
// snapshot and clears the live set; a query beat yields one result beat with
// the snapshot min, max and mean (unsigned 12.4, truncated), the last value
// and the live count of one channel. Unknown channels answer with zeros and
// no_samples set; an empty snapshot gives mean 0 and no_samples set. Results
// leave through a queue-style port (empty/pop) backed by one output register.
// Timing: the front classifies a beat and resolves its channel in the cycle
// it is accepted and drops it into a two-entry command queue. The back takes
// one command per cycle for samples and boundaries while it is idle. A query
// occupies the back while it captures the channel, runs the bit-serial
// restoring division of the snapshot total by its count (one quotient bit per
// cycle) and loads the output register; no other command is taken meanwhile.
// A query of an unknown channel or of an empty snapshot skips the division.
// The load waits while an unread result sits in the output register. The
// divider sets the query rate; full is raised only when the command queue
// holds two pending beats.
module multichannel_sample_statistics #(
  parameter int unsigned NUM_CHANNELS = mss_pkg::NUM_CHANNELS_DEF,  // 1..16
  parameter int unsigned COUNT_BITS   = mss_pkg::COUNT_BITS_DEF     // 8..32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  mss_pkg::in_item_t in_item_i,
  output logic              empty,
  input  logic              pop,
  output mss_pkg::result_t  result_o
);
  import mss_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_valid, cmd_pop, q_full, res_valid;

  assign full = q_full;

  // front: accept, classify, resolve channel
  mss_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decouples acceptance from the slow query path
  mss_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .valid_o (cmd_valid)
  );

  // back: statistics storage, divider, output register
  mss_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_out),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .result_o       (result_o),
    .result_valid_o (res_valid),
    .result_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

FILE: sv/mss_checker.sv
`default_nettype none

`include "multichannel_sample_statistics_defines.svh"

module mss_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input mss_pkg::result_t result_o
);
  import mss_pkg::*;

  logic waiting, has_data, no_data, mean_ok;

  assign waiting  = !empty && !pop;
  assign has_data = !empty && !result_o.no_samples;
  assign no_data  = !empty && result_o.no_samples;
  assign mean_ok  = (result_o.mean_value >= {result_o.min_sample, 4'b0000}) &&
                    (result_o.mean_value <= {result_o.max_sample, 4'b0000});

  // a waiting result beat holds until popped
  `MSS_ASSERT_NEXT(a_result_holds, waiting, !empty && $stable(result_o), "result moved")

  // a mean from a non-empty snapshot lies between its min and max
  `MSS_ASSERT_NOW(a_mean_bounds, has_data, mean_ok, "mean outside min/max")

  // no samples means no mean
  `MSS_ASSERT_NOW(a_empty_mean, no_data, result_o.mean_value == '0, "mean without samples")

endmodule

bind multichannel_sample_statistics mss_checker u_mss_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
